[rtl/tbgd_pkg.sv]
`default_nettype none
package tbgd_pkg;

   localparam int TIMER_BITS = 16;
   localparam int CFG_BITS = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int NUM_TIMERS = 4;
   localparam int SINCE_BITS = 16;

   localparam logic [63:0] TIMER_MAX = (64'd1 << TIMER_BITS) - 64'd1;

   // timer slots
   localparam int T_TAP = 0;
   localparam int T_HOLD = 1;
   localparam int T_SECOND = 2;
   localparam int T_DUAL = 3;

   localparam logic [CFG_BITS-1:0] TAP_WINDOW_RESET = 16'd300;
   localparam logic [CFG_BITS-1:0] HOLD_RESET = 16'd1000;
   localparam logic [CFG_BITS-1:0] SECOND_HOLD_RESET = 16'd2000;
   localparam logic [CFG_BITS-1:0] DUAL_HOLD_RESET = 16'd3000;
   localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET = 16'd50;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TAP_WINDOW  = 3'd0,
      CSR_HOLD        = 3'd1,
      CSR_SECOND_HOLD = 3'd2,
      CSR_DUAL_HOLD   = 3'd3,
      CSR_DEBOUNCE    = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      GEST_NONE   = 3'd0,
      GEST_SINGLE = 3'd1,
      GEST_DOUBLE = 3'd2,
      GEST_TRIPLE = 3'd3,
      GEST_HOLD   = 3'd4,
      GEST_SECOND = 3'd5,
      GEST_DUAL   = 3'd6
   } gesture_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] tap_window_ticks;
      logic [CFG_BITS-1:0] hold_ticks;
      logic [CFG_BITS-1:0] second_hold_ticks;
      logic [CFG_BITS-1:0] dual_hold_ticks;
      logic [CFG_BITS-1:0] debounce_ticks;
   } cfg_type;

   // counter load value, saturated to the timer width
   function automatic logic [TIMER_BITS-1:0] timer_load(input logic [CFG_BITS-1:0] ticks);
      logic [63:0] wide;
      wide = 64'(ticks);
      if (wide > TIMER_MAX) begin
         return TIMER_BITS'(TIMER_MAX);
      end
      return TIMER_BITS'(wide);
   endfunction

endpackage
`default_nettype wire

[rtl/tbgd_req_if.sv]
`default_nettype none
interface tbgd_req_if;
   logic valid;
   logic ready;
   logic first_level;
   logic second_level;
   logic first_rise;

   modport source (output valid, output first_level, output second_level,
                   output first_rise, input ready);
   modport sink (input valid, input first_level, input second_level,
                 input first_rise, output ready);
endinterface
`default_nettype wire

[rtl/tbgd_rsp_if.sv]
`default_nettype none
interface tbgd_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] gesture;

   modport source (output valid, output gesture, input ready);
   modport sink (input valid, input gesture, output ready);
endinterface
`default_nettype wire

[rtl/two_button_gesture_detector.sv]
`default_nettype none
// Two-button gesture detector, one transaction per timebase tick.
// req carries the tick: both button levels and the button-one rise flag.
// rsp carries one gesture code per tick: 0 none, 1 single, 2 double,
// 3 triple, 4 hold, 5 second hold, 6 dual hold.
// csr_* writes one of the five tick-count registers (index 0..4); other
// indexes are ignored. Write only while no transaction is in flight.
// A tick accepted from req lands in the input register; the engine evaluates it
// when it moves on, and its gesture is registered for rsp in the output register.
// Throughput: one tick per cycle while rsp does not stall; the state update of the
// engine, a loop through its state registers, is what sets it.
// Reset clears the tap, timer and guard state and loads the register
// defaults (300, 1000, 2000, 3000, 50 ticks).
// When rsp stalls, the output register holds its gesture and one more tick
// waits in the input register; req.ready drops only when both are full.
module two_button_gesture_detector (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   tbgd_req_if.sink                                  req,
   tbgd_rsp_if.source                                rsp,
   input  wire logic                                 csr_write_enable,
   input  wire logic [tbgd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [tbgd_pkg::CFG_BITS-1:0]        csr_data
);
   import tbgd_pkg::*;

   cfg_type     cfg;
   gesture_type gesture;

   logic in_valid_ff, in_valid_in;
   logic b1_ff, b2_ff, rise_ff;
   logic out_valid_ff, out_valid_in;
   logic [2:0] gesture_ff;
   logic move;
   logic take;

   tbgd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cfg              (cfg)
   );

   tbgd_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step    (move),
      .b1      (b1_ff),
      .b2      (b2_ff),
      .rise    (rise_ff),
      .cfg     (cfg),
      .gesture (gesture)
   );

   assign move = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || move;
   assign take = req.valid && req.ready;

   assign in_valid_in = take ? 1'b1 : (move ? 1'b0 : in_valid_ff);
   assign out_valid_in = move ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         b1_ff <= req.first_level;
         b2_ff <= req.second_level;
         rise_ff <= req.first_rise;
      end
      if (move) begin
         gesture_ff <= gesture;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.gesture = gesture_ff;
endmodule
`default_nettype wire

[rtl/tbgd_csr.sv]
`default_nettype none
module tbgd_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write_enable,
   input  wire logic [tbgd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [tbgd_pkg::CFG_BITS-1:0]        csr_data,
   output tbgd_pkg::cfg_type                         cfg
);
   import tbgd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TAP_WINDOW:  cfg_in.tap_window_ticks = csr_data;
            CSR_HOLD:        cfg_in.hold_ticks = csr_data;
            CSR_SECOND_HOLD: cfg_in.second_hold_ticks = csr_data;
            CSR_DUAL_HOLD:   cfg_in.dual_hold_ticks = csr_data;
            CSR_DEBOUNCE:    cfg_in.debounce_ticks = csr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tap_window_ticks <= TAP_WINDOW_RESET;
         cfg_ff.hold_ticks <= HOLD_RESET;
         cfg_ff.second_hold_ticks <= SECOND_HOLD_RESET;
         cfg_ff.dual_hold_ticks <= DUAL_HOLD_RESET;
         cfg_ff.debounce_ticks <= DEBOUNCE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule
`default_nettype wire

[rtl/tbgd_engine.sv]
`default_nettype none
module tbgd_engine (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic                  b1,
   input  wire logic                  b2,
   input  wire logic                  rise,
   input  wire tbgd_pkg::cfg_type     cfg,
   output tbgd_pkg::gesture_type      gesture
);
   import tbgd_pkg::*;

   logic [1:0]            taps_ff, taps_in;
   logic [TIMER_BITS-1:0] left_ff [NUM_TIMERS];
   logic [TIMER_BITS-1:0] left_in [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] act_ff, act_in;
   logic [NUM_TIMERS-1:0] exp_ff, exp_in;
   logic [SINCE_BITS-1:0] since_ff, since_in;
   logic                  g_second_ff, g_second_in;
   logic                  g_dual_ff, g_dual_in;

   always_comb begin
      logic second_fired;
      logic accepted;
      logic triple;
      second_fired = 1'b0;
      accepted = 1'b0;
      triple = 1'b0;
      gesture = GEST_NONE;
      taps_in = taps_ff;
      act_in = act_ff;
      exp_in = exp_ff;
      g_second_in = g_second_ff;
      g_dual_in = g_dual_ff;
      since_in = (since_ff == {SINCE_BITS{1'b1}}) ? since_ff : since_ff + 1'b1;

      // one-shot counters tick first
      for (int t = 0; t < NUM_TIMERS; t++) begin
         left_in[t] = left_ff[t];
         if (act_ff[t]) begin
            if (left_ff[t] <= TIMER_BITS'(1)) begin
               left_in[t] = '0;
               act_in[t] = 1'b0;
               exp_in[t] = 1'b1;
            end else begin
               left_in[t] = left_ff[t] - 1'b1;
            end
         end
      end

      if (b1 && b2) begin
         taps_in = '0;
         exp_in[T_TAP] = 1'b0;
         exp_in[T_HOLD] = 1'b0;
         act_in[T_TAP] = 1'b0;
         act_in[T_HOLD] = 1'b0;
         if (act_in[T_SECOND]) begin
            act_in[T_SECOND] = 1'b0;
            exp_in[T_SECOND] = 1'b0;
            g_second_in = 1'b0;
         end
         if (!g_dual_in) begin
            if (exp_in[T_DUAL]) begin
               g_dual_in = 1'b1;
               gesture = GEST_DUAL;
            end else if (!act_in[T_DUAL]) begin
               left_in[T_DUAL] = timer_load(cfg.dual_hold_ticks);
               act_in[T_DUAL] = 1'b1;
            end
         end
      end else begin
         act_in[T_DUAL] = 1'b0;
         exp_in[T_DUAL] = 1'b0;
         if (!b1 && !b2) begin
            g_dual_in = 1'b0;
         end
         if (b2) begin
            if (!g_second_in) begin
               if (exp_in[T_SECOND]) begin
                  g_second_in = 1'b1;
                  gesture = GEST_SECOND;
                  second_fired = 1'b1;
               end else if (!act_in[T_SECOND]) begin
                  left_in[T_SECOND] = timer_load(cfg.second_hold_ticks);
                  act_in[T_SECOND] = 1'b1;
               end
            end
         end else begin
            act_in[T_SECOND] = 1'b0;
            exp_in[T_SECOND] = 1'b0;
            g_second_in = 1'b0;
         end

         // a rise on the second-hold tick is dropped
         if (!second_fired) begin
            accepted = rise && (since_in >= cfg.debounce_ticks);
            if (accepted) begin
               since_in = '0;
               if (taps_in == 2'd0) begin
                  taps_in = 2'd1;
                  exp_in[T_TAP] = 1'b0;
                  exp_in[T_HOLD] = 1'b0;
                  left_in[T_TAP] = timer_load(cfg.tap_window_ticks);
                  left_in[T_HOLD] = timer_load(cfg.hold_ticks);
                  act_in[T_TAP] = 1'b1;
                  act_in[T_HOLD] = 1'b1;
               end else if (!exp_in[T_TAP] && taps_in == 2'd1) begin
                  taps_in = 2'd2;
                  left_in[T_TAP] = timer_load(cfg.tap_window_ticks);
                  act_in[T_TAP] = 1'b1;
               end else if (!exp_in[T_TAP] && taps_in == 2'd2) begin
                  triple = 1'b1;
               end
            end

            if (triple) begin
               gesture = GEST_TRIPLE;
            end else if (exp_in[T_TAP] && taps_in == 2'd1 && !b1) begin
               gesture = GEST_SINGLE;
            end else if (exp_in[T_TAP] && taps_in == 2'd2) begin
               gesture = GEST_DOUBLE;
            end else if (exp_in[T_HOLD] && taps_in == 2'd1 && b1) begin
               gesture = GEST_HOLD;
            end

            if (gesture != GEST_NONE) begin
               taps_in = '0;
               exp_in[T_TAP] = 1'b0;
               exp_in[T_HOLD] = 1'b0;
               act_in[T_TAP] = 1'b0;
               act_in[T_HOLD] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taps_ff <= '0;
         act_ff <= '0;
         exp_ff <= '0;
         since_ff <= '0;
         g_second_ff <= 1'b0;
         g_dual_ff <= 1'b0;
         for (int t = 0; t < NUM_TIMERS; t++) begin
            left_ff[t] <= '0;
         end
      end else if (step) begin
         taps_ff <= taps_in;
         act_ff <= act_in;
         exp_ff <= exp_in;
         since_ff <= since_in;
         g_second_ff <= g_second_in;
         g_dual_ff <= g_dual_in;
         for (int t = 0; t < NUM_TIMERS; t++) begin
            left_ff[t] <= left_in[t];
         end
      end
   end
endmodule
`default_nettype wire
